// File: rtl/core/mm3_pkg.sv
// ----------------------------------------------------------------------------
// MurmurHash3 32-bit stream package
// Constants, operand codes and the command and status types shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mm3_pkg;

  localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2   = 32'h1b873593;
  localparam logic [31:0] FOLD_ADD = 32'he6546b64;
  localparam logic [31:0] AVAL_M1  = 32'h85ebca6b;
  localparam logic [31:0] AVAL_M2  = 32'hc2b2ae35;

  localparam int unsigned MIX_ROT  = 15;
  localparam int unsigned FOLD_ROT = 13;

  localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

  // Operand selection for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_MIX1,
    MUL_MIX2,
    MUL_AVAL1,
    MUL_AVAL2
  } mul_op_t;

  typedef struct packed {
    logic    load;     // capture an accepted request
    logic    mul_en;   // write the product register
    mul_op_t mul_op;
    logic    mix;      // fold or xor the mixed word into the accumulator
    logic    fin;      // xor in the length and do the first shift step
    logic    emit;     // load the output register, close the message
  } mm3_cmd_t;

  typedef struct packed {
    logic last;        // the request being worked on ends its message
  } mm3_status_t;

endpackage

// File: rtl/core/mm3_ctrl.sv
// ----------------------------------------------------------------------------
// MurmurHash3 32-bit stream controller
// Sequences each request through the shared multiplier and drives the
// handshake of both channels.
// ----------------------------------------------------------------------------
module mm3_ctrl
  import mm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  mm3_status_t status,
  output mm3_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MIX,
    ST_FIN,
    ST_AV1,
    ST_AV2,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   emit_ok;

  // The output register may be reloaded once it is empty or being taken.
  assign emit_ok   = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.mul_op    = MUL_MIX1;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_MIX1;
        state_nxt  = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_MIX2;
        state_nxt  = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = status.last ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_AV1;
      end
      ST_AV1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_AVAL1;
        state_nxt  = ST_AV2;
      end
      ST_AV2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_AVAL2;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_ok) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/mm3_datapath.sv
// ----------------------------------------------------------------------------
// MurmurHash3 32-bit stream datapath
// Seed, accumulator, byte counter, one shared multiplier with its product
// register, and the output register.
// ----------------------------------------------------------------------------
module mm3_datapath
  import mm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_seed,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  input  mm3_cmd_t    cmd,
  output mm3_status_t status,
  output logic [31:0] out_hash_value
);

  logic [31:0] seed_r;
  logic        msg_open_r;
  logic [31:0] word_r;
  logic        full_r;
  logic        last_r;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] bytes_r;
  logic [31:0] prod_r;
  logic [31:0] hash_r;

  logic        in_full;
  logic [31:0] in_masked;
  logic [2:0]  in_add;
  logic [31:0] acc_base, bytes_base;
  logic [31:0] mul_a, mul_b;
  logic [31:0] fold_x, fold_r;
  logic [31:0] fin_h;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // Words before the last are always taken as four bytes.
  assign in_full = !in_last_word || (in_byte_count >= FULL_WORD_BYTES);
  assign in_add  = in_full ? FULL_WORD_BYTES : in_byte_count;

  always_comb begin
    in_masked = in_message_word;
    if (!in_full) begin
      unique case (in_byte_count[1:0])
        2'd0: in_masked = 32'h0;
        2'd1: in_masked = {24'h0, in_message_word[7:0]};
        2'd2: in_masked = {16'h0, in_message_word[15:0]};
        2'd3: in_masked = {8'h0, in_message_word[23:0]};
        default: in_masked = in_message_word;
      endcase
    end
  end

  assign acc_base   = msg_open_r ? acc_r : seed_r;
  assign bytes_base = msg_open_r ? bytes_r : 32'h0;

  always_comb begin
    unique case (cmd.mul_op)
      MUL_MIX1: begin
        mul_a = word_r;
        mul_b = MIX_C1;
      end
      MUL_MIX2: begin
        mul_a = rotl(prod_r, MIX_ROT);
        mul_b = MIX_C2;
      end
      MUL_AVAL1: begin
        mul_a = acc_r;
        mul_b = AVAL_M1;
      end
      MUL_AVAL2: begin
        mul_a = prod_r ^ (prod_r >> 13);
        mul_b = AVAL_M2;
      end
      default: begin
        mul_a = word_r;
        mul_b = MIX_C1;
      end
    endcase
  end

  // Times five is a shift and an add.
  assign fold_x = acc_r ^ prod_r;
  assign fold_r = rotl(fold_x, FOLD_ROT);
  assign fin_h  = acc_r ^ bytes_r;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.load) begin
      acc_nxt = acc_base;
    end else if (cmd.mix) begin
      acc_nxt = full_r ? ((fold_r << 2) + fold_r + FOLD_ADD) : fold_x;
    end else if (cmd.fin) begin
      acc_nxt = fin_h ^ (fin_h >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= 32'h0;
      msg_open_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_seed;
      end
      if (cmd.load) begin
        msg_open_r <= 1'b1;
      end else if (cmd.emit) begin
        msg_open_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.load) begin
      word_r  <= in_masked;
      full_r  <= in_full;
      last_r  <= in_last_word;
      bytes_r <= bytes_base + {29'h0, in_add};
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.emit) begin
      hash_r <= prod_r ^ (prod_r >> 16);
    end
  end

  assign status.last    = last_r;
  assign out_hash_value = hash_r;

endmodule

// File: rtl/core/murmur3_32_hash_stream_unit.sv
// ----------------------------------------------------------------------------
// MurmurHash3 32-bit stream unit
// Hashes messages that arrive as little-endian 32-bit words and returns one
// 32-bit hash per message.
// ----------------------------------------------------------------------------
// Usage: each request on the in_ channel carries a word, its number of valid
// bytes and a last flag. Words before the last are always taken as four
// bytes; the last may hold zero to four. An empty message is a single last
// request with a count of zero.
// The seed is written through cfg_we and cfg_seed while the unit is idle, a
// rule for the user that the unit itself does not enforce; it applies from the next message start.
// Throughput: one request is worked on at a time, so the next request is
// accepted only when the unit is back in idle. A word that does not end its
// message passes twice through the single shared 32 by 32 multiplier for the
// key mix; a last word also passes twice more through it for the final mix,
// one pass per cycle.
// Sequence: after the last word is accepted the unit does the key mix, the
// length and shift step and the final mix, then loads the hash into the
// output register with out_valid once the output is free.
// Stalls: the hash sits in an output register, so the next message may be
// accepted while it waits. If it is still waiting when the next hash is
// ready, the unit holds in its final step with in_ready low until it is taken.
// Reset clears the seed to zero, closes any open message and empties the
// output register.
// ----------------------------------------------------------------------------
module murmur3_32_hash_stream_unit
  import mm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value
);

  mm3_cmd_t    cmd;
  mm3_status_t status;

  // The controller sequences the steps of each request; the datapath holds
  // every value and the shared multiplier.
  mm3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mm3_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_seed        (cfg_seed),
    .in_message_word (in_message_word),
    .in_byte_count   (in_byte_count),
    .in_last_word    (in_last_word),
    .cmd             (cmd),
    .status          (status),
    .out_hash_value  (out_hash_value)
  );

endmodule
